// ----- src/qte_pkg.sv -----
package qte_pkg;

    // Field widths
    localparam int QW      = 16;   // quaternion component, Q1.14
    localparam int AW      = 16;   // yaw and roll, Q2.13
    localparam int PW      = 15;   // pitch, Q1.13

    // Internal widths
    localparam int PRODW   = 32;   // product of two components
    localparam int SUMW    = 34;   // doubled sums, Q28
    localparam int SW      = 30;   // clamped asin argument, Q28
    localparam int SAW     = 29;   // magnitude of the asin argument
    localparam int NW      = 58;   // sqrt radicand, padded to an even width
    localparam int ROOTW   = 29;   // sqrt result
    localparam int REMW    = 34;   // sqrt partial remainder
    localparam int XW      = 38;   // CORDIC x and y
    localparam int ZW      = 32;   // CORDIC angle, radians * 2^28
    localparam int RW      = ZW - 15;  // rounded angle before clamping

    localparam int SQRT_STAGES   = NW / 2;
    localparam int ATAN_LEN      = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int YAW_LIMIT   = 25736;
    localparam int PITCH_LIMIT = 12868;

    localparam logic signed [SUMW-1:0] ONE_Q28  = SUMW'(64'sd268435456);
    localparam logic signed [SUMW-1:0] MONE_Q28 = -SUMW'(64'sd268435456);
    localparam logic [NW-1:0]          ONE_Q56  = NW'(1) << 56;

    // Operands carried alongside the square root
    typedef struct packed {
        logic signed [SUMW-1:0] yn;
        logic signed [SUMW-1:0] yd;
        logic signed [SUMW-1:0] rn;
        logic signed [SUMW-1:0] rd;
        logic signed [SW-1:0]   s;
    } op_t;

    // round(atan(2^-i) * 2^28)
    function automatic logic signed [ZW-1:0] atan_val(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            10:      v = 32'sd262144;
            11:      v = 32'sd131072;
            12:      v = 32'sd65536;
            13:      v = 32'sd32768;
            14:      v = 32'sd16384;
            15:      v = 32'sd8192;
            16:      v = 32'sd4096;
            17:      v = 32'sd2048;
            18:      v = 32'sd1024;
            19:      v = 32'sd512;
            20:      v = 32'sd256;
            21:      v = 32'sd128;
            22:      v = 32'sd64;
            23:      v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round an angle to Q2.13 and clamp it to +/- lim
    function automatic logic signed [RW-1:0] round_clamp(input logic signed [ZW-1:0] a,
                                                          input int lim);
        logic signed [ZW:0]   t;
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] hi;
        t  = (ZW+1)'(a) + (ZW+1)'(32'sd16384);
        r  = RW'(t >>> 15);
        hi = RW'(lim);
        if (r > hi) begin
            r = hi;
        end else if (r < -hi) begin
            r = -hi;
        end
        return r;
    endfunction

endpackage

// ----- src/quaternion_to_euler_core.sv -----
// Quaternion to Euler angles (Z-Y-X), fully pipelined.
//
// Input channel s_*: one attitude quaternion per item (quat_w/x/y/z, signed
// Q1.14). Result channel m_*: yaw, roll (16 bit, signed Q2.13) and pitch
// (15 bit, signed Q1.13), radians. Every accepted quaternion gives exactly one result item.
//
// From acceptance to m_valid an item passes the registers of products,
// sums, the square of the asin argument and 1 - s*s, the bit-per-stage
// square root, a pre-rotation register, a register for each CORDIC
// iteration and a rounding/output register.
// Throughput is one item per cycle while m_ready is high.
//
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops in the same cycle; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; payload registers are
// not reset. The block keeps no state between items.
module quaternion_to_euler_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [QW-1:0] s_quat_w,
    input  logic signed [QW-1:0] s_quat_x,
    input  logic signed [QW-1:0] s_quat_y,
    input  logic signed [QW-1:0] s_quat_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [AW-1:0] m_yaw_angle,
    output logic signed [PW-1:0] m_pitch_angle,
    output logic signed [AW-1:0] m_roll_angle
);

    localparam int NSTEP    = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int ST_PRE   = 4 + SQRT_STAGES;
    localparam int NSTAGE   = ST_PRE + 1 + NSTEP;
    localparam int DLY      = SQRT_STAGES + 3;

    logic en;
    logic vld_reg [0:NSTAGE-1];
    logic m_valid_reg;

    // Advance whenever the output slot is free or being taken
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTAGE; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < NSTAGE; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= vld_reg[NSTAGE-1];
        end
    end

    // Stage 1: products
    logic signed [PRODW-1:0] p_wz_reg, p_xy_reg, p_ww_reg, p_xx_reg, p_wx_reg;
    logic signed [PRODW-1:0] p_yz_reg, p_zz_reg, p_wy_reg, p_xz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wz_reg <= s_quat_w * s_quat_z;
            p_xy_reg <= s_quat_x * s_quat_y;
            p_ww_reg <= s_quat_w * s_quat_w;
            p_xx_reg <= s_quat_x * s_quat_x;
            p_wx_reg <= s_quat_w * s_quat_x;
            p_yz_reg <= s_quat_y * s_quat_z;
            p_zz_reg <= s_quat_z * s_quat_z;
            p_wy_reg <= s_quat_w * s_quat_y;
            p_xz_reg <= s_quat_x * s_quat_z;
        end
    end

    // Stage 2: doubled sums, clamp the asin argument
    op_t                   op_next;
    logic [SAW-1:0]        s_abs_next;
    logic signed [SUMW-1:0] s_raw;
    logic signed [SUMW-1:0] s_cl;
    op_t                   op_reg [0:DLY-1];
    logic [SAW-1:0]        s_abs_reg;

    always_comb begin
        op_next.yn = (SUMW'(p_wz_reg) + SUMW'(p_xy_reg)) <<< 1;
        op_next.yd = ((SUMW'(p_ww_reg) + SUMW'(p_xx_reg)) <<< 1) - ONE_Q28;
        op_next.rn = (SUMW'(p_wx_reg) + SUMW'(p_yz_reg)) <<< 1;
        op_next.rd = ((SUMW'(p_ww_reg) + SUMW'(p_zz_reg)) <<< 1) - ONE_Q28;
        s_raw      = (SUMW'(p_wy_reg) - SUMW'(p_xz_reg)) <<< 1;
        if (s_raw > ONE_Q28) begin
            s_cl = ONE_Q28;
        end else if (s_raw < MONE_Q28) begin
            s_cl = MONE_Q28;
        end else begin
            s_cl = s_raw;
        end
        op_next.s  = SW'(s_cl);
        s_abs_next = s_cl[SUMW-1] ? SAW'(-s_cl) : SAW'(s_cl);
    end

    // Delay the atan2 operands past the square root
    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[0] <= op_next;
            s_abs_reg <= s_abs_next;
            for (int k = 1; k < DLY; k++) begin
                op_reg[k] <= op_reg[k-1];
            end
        end
    end

    // Stage 3: square the argument; stage 4: form 1 - s*s
    logic [NW-1:0]   sq_full;
    logic [NW-2:0]   sq_reg;
    logic [NW-1:0]   nn_reg   [0:SQRT_STAGES];
    logic [REMW-1:0] rem_reg  [0:SQRT_STAGES];
    logic [ROOTW-1:0] root_reg [0:SQRT_STAGES];

    assign sq_full = {{(NW-SAW){1'b0}}, s_abs_reg} * {{(NW-SAW){1'b0}}, s_abs_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= sq_full[NW-2:0];
            nn_reg[0]   <= ONE_Q56 - {1'b0, sq_reg};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
        logic [REMW-1:0]  rem_sh;
        logic [REMW-1:0]  trial;
        logic             take;

        always_comb begin
            rem_sh = {rem_reg[j][REMW-3:0], nn_reg[j][2*(SQRT_STAGES-1-j) +: 2]};
            trial  = {{(REMW-ROOTW-2){1'b0}}, root_reg[j], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nn_reg[j+1]   <= nn_reg[j];
                rem_reg[j+1]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[j+1] <= {root_reg[j][ROOTW-2:0], take};
            end
        end
    end

    // Pre-rotation: lane 0 yaw, lane 1 pitch, lane 2 roll
    logic signed [XW-1:0] cx_reg [0:2][0:NSTEP];
    logic signed [XW-1:0] cy_reg [0:2][0:NSTEP];
    logic signed [ZW-1:0] cz_reg [0:2][0:NSTEP];
    logic                 zf_reg [0:2][0:NSTEP];
    logic signed [XW-1:0] pre_x [0:2];
    logic signed [XW-1:0] pre_y [0:2];

    always_comb begin
        pre_y[0] = XW'(op_reg[DLY-1].yn);
        pre_x[0] = XW'(op_reg[DLY-1].yd);
        pre_y[1] = XW'(op_reg[DLY-1].s);
        pre_x[1] = XW'({1'b0, root_reg[SQRT_STAGES]});
        pre_y[2] = XW'(op_reg[DLY-1].rn);
        pre_x[2] = XW'(op_reg[DLY-1].rd);
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        // Fold a negative x into the right half-plane
        always_ff @(posedge aclk) begin
            if (en) begin
                zf_reg[l][0] <= (pre_x[l] == '0) && (pre_y[l] == '0);
                if (pre_x[l] < 0) begin
                    if (pre_y[l] >= 0) begin
                        cx_reg[l][0] <= pre_y[l];
                        cy_reg[l][0] <= -pre_x[l];
                        cz_reg[l][0] <= atan_val(0) <<< 1;
                    end else begin
                        cx_reg[l][0] <= -pre_y[l];
                        cy_reg[l][0] <= pre_x[l];
                        cz_reg[l][0] <= -(atan_val(0) <<< 1);
                    end
                end else begin
                    cx_reg[l][0] <= pre_x[l];
                    cy_reg[l][0] <= pre_y[l];
                    cz_reg[l][0] <= '0;
                end
            end
        end

        // Vectoring iterations, one per stage
        for (genvar i = 0; i < NSTEP; i++) begin : g_step
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;

            assign xs = cx_reg[l][i] >>> i;
            assign ys = cy_reg[l][i] >>> i;

            always_ff @(posedge aclk) begin
                if (en) begin
                    zf_reg[l][i+1] <= zf_reg[l][i];
                    if (cy_reg[l][i] >= 0) begin
                        cx_reg[l][i+1] <= cx_reg[l][i] + ys;
                        cy_reg[l][i+1] <= cy_reg[l][i] - xs;
                        cz_reg[l][i+1] <= cz_reg[l][i] + atan_val(i);
                    end else begin
                        cx_reg[l][i+1] <= cx_reg[l][i] - ys;
                        cy_reg[l][i+1] <= cy_reg[l][i] + xs;
                        cz_reg[l][i+1] <= cz_reg[l][i] - atan_val(i);
                    end
                end
            end
        end
    end

    // Round, clamp and hold the result until taken
    logic signed [ZW-1:0] ang [0:2];
    logic signed [RW-1:0] yaw_r, pitch_r, roll_r;
    logic signed [AW-1:0] yaw_reg, roll_reg;
    logic signed [PW-1:0] pitch_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            ang[l] = zf_reg[l][NSTEP] ? '0 : cz_reg[l][NSTEP];
        end
        yaw_r   = round_clamp(ang[0], YAW_LIMIT);
        pitch_r = round_clamp(ang[1], PITCH_LIMIT);
        roll_r  = round_clamp(ang[2], YAW_LIMIT);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_reg   <= AW'(yaw_r);
            pitch_reg <= PW'(pitch_r);
            roll_reg  <= AW'(roll_r);
        end
    end

    assign m_yaw_angle   = yaw_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_roll_angle  = roll_reg;

`ifndef SYNTHESIS
    a_ready_tracks_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the output slot");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= PW'(PITCH_LIMIT)) && (m_pitch_angle >= -PW'(PITCH_LIMIT)))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_yaw_angle <= AW'(YAW_LIMIT)) && (m_yaw_angle >= -AW'(YAW_LIMIT)))
        else $error("yaw out of range");
`endif

endmodule

// ----- dv/quaternion_to_euler_checker.sv -----
`timescale 1ns / 1ps

module quaternion_to_euler_checker
    import qte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [QW-1:0] s_quat_w,
    input  logic signed [QW-1:0] s_quat_x,
    input  logic signed [QW-1:0] s_quat_y,
    input  logic signed [QW-1:0] s_quat_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [AW-1:0] m_yaw_angle,
    input  logic signed [PW-1:0] m_pitch_angle,
    input  logic signed [AW-1:0] m_roll_angle,
    output int                   fail_count,
    output int                   pending_count
);

    typedef struct packed {
        logic signed [AW-1:0] yaw;
        logic signed [PW-1:0] pitch;
        logic signed [AW-1:0] roll;
    } euler_t;

    localparam longint ONE = 64'sd1 << 28;

    // arctangent of 2^-i, radians * 2^28
    longint arctan_step [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    euler_t angles_due [$];

    // Vectoring rotation: return atan2(yv, xv) in radians * 2^28
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint ang;
        longint t;
        longint xs;
        longint ys;
        int     steps;
        ang = 0;
        if (xv == 0 && yv == 0) begin
            return 0;
        end
        if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -t;
                ang = arctan_step[0] * 2;
            end else begin
                xv = -yv;
                yv = t;
                ang = -arctan_step[0] * 2;
            end
        end
        steps = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
        for (int i = 0; i < steps; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                ang = ang + arctan_step[i];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                ang = ang - arctan_step[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint to_q13(input longint a, input longint lim);
        longint r;
        r = (a + 64'sd16384) >>> 15;
        if (r > lim) begin
            r = lim;
        end
        if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    function automatic euler_t euler_of(input longint w, input longint x,
                                        input longint y, input longint z);
        euler_t e;
        longint yn;
        longint yd;
        longint rn;
        longint rd;
        longint s;
        longint c;
        yn = 2 * (w * z + x * y);
        yd = 2 * (w * w + x * x) - ONE;
        rn = 2 * (w * x + y * z);
        rd = 2 * (w * w + z * z) - ONE;
        s  = 2 * (w * y - x * z);
        if (s > ONE) begin
            s = ONE;
        end
        if (s < -ONE) begin
            s = -ONE;
        end
        c = longint'(floor_sqrt(longint'(ONE * ONE - s * s)));
        e.yaw   = AW'(to_q13(vector_angle(yn, yd), YAW_LIMIT));
        e.pitch = PW'(to_q13(vector_angle(s, c), PITCH_LIMIT));
        e.roll  = AW'(to_q13(vector_angle(rn, rd), YAW_LIMIT));
        return e;
    endfunction

    // Predict on each accepted quaternion, compare each accepted result
    always @(posedge aclk) begin
        euler_t want;
        int     errs;
        errs = 0;
        if (!aresetn) begin
            angles_due.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (s_valid && s_ready) begin
                angles_due.push_back(euler_of(s_quat_w, s_quat_x, s_quat_y, s_quat_z));
            end
            if (m_valid && m_ready) begin
                if (angles_due.size() == 0) begin
                    $error("result item with no quaternion pending");
                    errs = errs + 1;
                end else begin
                    want = angles_due.pop_front();
                    if (m_yaw_angle !== want.yaw) begin
                        $error("yaw_angle expected %0d actual %0d", want.yaw, m_yaw_angle);
                        errs = errs + 1;
                    end
                    if (m_pitch_angle !== want.pitch) begin
                        $error("pitch_angle expected %0d actual %0d",
                               want.pitch, m_pitch_angle);
                        errs = errs + 1;
                    end
                    if (m_roll_angle !== want.roll) begin
                        $error("roll_angle expected %0d actual %0d", want.roll, m_roll_angle);
                        errs = errs + 1;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            pending_count <= angles_due.size();
        end
    end

endmodule

// ----- dv/quaternion_to_euler_core_test.sv -----
`timescale 1ns / 1ps

module quaternion_to_euler_core_test;
    import qte_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [QW-1:0] s_quat_w = '0;
    logic signed [QW-1:0] s_quat_x = '0;
    logic signed [QW-1:0] s_quat_y = '0;
    logic signed [QW-1:0] s_quat_z = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [AW-1:0] m_yaw_angle;
    logic signed [PW-1:0] m_pitch_angle;
    logic signed [AW-1:0] m_roll_angle;
    int                   fail_count;
    int                   pending_count;
    bit                   no_idle = 1'b0;

    always #5 aclk = ~aclk;

    quaternion_to_euler_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_yaw_angle(m_yaw_angle), .m_pitch_angle(m_pitch_angle),
        .m_roll_angle(m_roll_angle)
    );

    quaternion_to_euler_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x),
        .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_yaw_angle(m_yaw_angle), .m_pitch_angle(m_pitch_angle),
        .m_roll_angle(m_roll_angle),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Stall the result side at random outside the quiet stretch
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 13);
        end
    end

    // Offer one quaternion and hold it until accepted
    task automatic send_quat(input int w, input int x, input int y, input int z);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_quat_w <= QW'(w);
        s_quat_x <= QW'(x);
        s_quat_y <= QW'(y);
        s_quat_z <= QW'(z);
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic int rand_comp();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    initial begin
        real fw, fx, fy, fz, mag;
        int  w, x, y, z;
        int  kind;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, identity, axis turns, gimbal lock and saturated asin
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, -16384, 0, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, -16384, 16384, -16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(8192, 8192, 8192, -8192);
        send_quat(16384, 0, 16384, 0);
        send_quat(16384, 0, -16384, 0);
        send_quat(0, 16384, 0, 16384);
        send_quat(11585, 0, 0, 11585);
        send_quat(11585, 0, 0, -11585);
        send_quat(0, 0, 0, -16384);
        send_quat(1, -1, 1, -1);
        send_quat(-1, 1, -1, 1);

        // Random part: mostly unit quaternions, some raw components
        for (int n = 0; n < 1050; n++) begin
            no_idle = (n >= 400 && n < 600);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                fw = $itor(rand_comp());
                fx = $itor(rand_comp());
                fy = $itor(rand_comp());
                fz = $itor(rand_comp());
                mag = $sqrt(fw * fw + fx * fx + fy * fy + fz * fz);
                if (mag < 1.0) begin
                    mag = 1.0;
                end
                w = $rtoi(fw * 16383.0 / mag);
                x = $rtoi(fx * 16383.0 / mag);
                y = $rtoi(fy * 16383.0 / mag);
                z = $rtoi(fz * 16383.0 / mag);
            end else begin
                w = rand_comp();
                x = rand_comp();
                y = rand_comp();
                z = rand_comp();
            end
            send_quat(w, x, y, z);
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        // Drain, then allow the pipeline depth
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
